FILE: src/tsd_pkg.sv
// shared types, constants and helpers for the timestamp difference pipeline
package tsd_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned YEAR_X_W = 15;
    localparam int unsigned DAYS_W   = 23;
    localparam int unsigned TOD_W    = 17;
    localparam int unsigned SECS_W   = 40;
    localparam int unsigned Q_W      = 8;
    localparam int unsigned PART_W   = 13;

    localparam logic [YEAR_X_W-1:0] YEAR_SHIFT    = 15'd400;
    localparam logic [3:0]          MONTH_JAN     = 4'd1;
    localparam logic [3:0]          MONTH_FEB     = 4'd2;
    localparam logic [3:0]          MONTH_DEC     = 4'd12;
    localparam logic [16:0]         SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0]         SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]          SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]          DAYS_PER_YEAR = 9'd365;
    localparam logic [15:0]         RECIP_25      = 16'd41944;
    localparam int unsigned         RECIP_SHIFT   = 20;

    localparam logic [8:0] CUM_DAYS [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // per-stage load enables shared by both converters
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_adv;

    // exact x / 25 for x below 6400
    function automatic logic [Q_W-1:0] div25(input logic [12:0] x);
        logic [28:0] prod;
        prod = 29'(x) * 29'(RECIP_25);
        return Q_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

FILE: src/timestamp_seconds_difference_top.sv
// top level: two date-time converters, difference stage and pipeline flow control
//
// Takes a pair of calendar date-times on the input channel (i_valid / o_ready)
// and returns the signed second count from the first to the second on the
// output channel (o_valid / i_ready), one result per request, in order.
// The datapath is five register stages: year/month prep with reciprocal
// divides, day-count partial sums, total days, days times 86400, and the
// final subtraction held in the output register.
// When the output is not stalled, a request moves through the four converter
// stages and then the output register, where o_valid rises with its result.
// Throughput: one request per cycle while i_ready stays high; the rate is set
// by the five-stage pipeline, each stage holding one request.
// Each stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up while the receiver stalls; o_ready
// drops only when all five stages hold requests and i_ready is low.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset.
module timestamp_seconds_difference_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [13:0]         i_from_year,
    input  logic [3:0]          i_from_month,
    input  logic [4:0]          i_from_day,
    input  logic [4:0]          i_from_hour,
    input  logic [5:0]          i_from_minute,
    input  logic [5:0]          i_from_second,
    input  logic [13:0]         i_to_year,
    input  logic [3:0]          i_to_month,
    input  logic [4:0]          i_to_day,
    input  logic [4:0]          i_to_hour,
    input  logic [5:0]          i_to_minute,
    input  logic [5:0]          i_to_second,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [39:0]  o_seconds_between
);

    logic [4:0]                 r_v;
    logic [4:0]                 w_ld;
    tsd_pkg::t_adv              w_adv;
    logic [tsd_pkg::SECS_W-1:0] w_secs_from, w_secs_to;
    logic signed [39:0]         r_out;

    // stage k loads when empty or when its contents move on
    always_comb begin
        w_ld[4] = !r_v[4] || i_ready;
        w_ld[3] = !r_v[3] || w_ld[4];
        w_ld[2] = !r_v[2] || w_ld[3];
        w_ld[1] = !r_v[1] || w_ld[2];
        w_ld[0] = !r_v[0] || w_ld[1];
    end

    assign w_adv.ld1 = w_ld[0];
    assign w_adv.ld2 = w_ld[1];
    assign w_adv.ld3 = w_ld[2];
    assign w_adv.ld4 = w_ld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[0]) r_v[0] <= i_valid;
            if (w_ld[1]) r_v[1] <= r_v[0];
            if (w_ld[2]) r_v[2] <= r_v[1];
            if (w_ld[3]) r_v[3] <= r_v[2];
            if (w_ld[4]) r_v[4] <= r_v[3];
        end
    end

    tsd_abs_sec u_from (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_year   (i_from_year),
        .i_month  (i_from_month),
        .i_day    (i_from_day),
        .i_hour   (i_from_hour),
        .i_minute (i_from_minute),
        .i_second (i_from_second),
        .o_secs   (w_secs_from)
    );

    tsd_abs_sec u_to (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_year   (i_to_year),
        .i_month  (i_to_month),
        .i_day    (i_to_day),
        .i_hour   (i_to_hour),
        .i_minute (i_to_minute),
        .i_second (i_to_second),
        .o_secs   (w_secs_to)
    );

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_out <= signed'(w_secs_to - w_secs_from);
        end
    end

    assign o_ready           = w_ld[0];
    assign o_valid           = r_v[4];
    assign o_seconds_between = r_out;

`ifndef SYNTHESIS
    // an empty first stage always takes a request
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> o_ready)
        else $error("empty entry stage refused a request");

    // backpressure only when every stage is occupied
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> ((&r_v) && !i_ready))
        else $error("input stalled with a free stage");

    // a request leaving the last converter stage reaches the output
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && w_ld[4]) |=> o_valid)
        else $error("request lost before output register");
`endif

endmodule

FILE: src/tsd_abs_sec.sv
// four-stage conversion of one calendar date-time to an absolute second count
module tsd_abs_sec (
    input  logic                         i_clk,
    input  tsd_pkg::t_adv                i_adv,
    input  logic [tsd_pkg::YEAR_W-1:0]   i_year,
    input  logic [3:0]                   i_month,
    input  logic [4:0]                   i_day,
    input  logic [4:0]                   i_hour,
    input  logic [5:0]                   i_minute,
    input  logic [5:0]                   i_second,
    output logic [tsd_pkg::SECS_W-1:0]   o_secs
);

    // stage 1: year shift, month clamp, reciprocal divides
    logic [tsd_pkg::YEAR_X_W-1:0] n_year, n_prev;
    logic [3:0]                   n_month;
    logic [tsd_pkg::YEAR_X_W-1:0] r_year, r_prev;
    logic [3:0]                   r_month;
    logic [4:0]                   r_day, r_hour;
    logic [5:0]                   r_minute, r_second;
    logic [tsd_pkg::Q_W-1:0]      r_q100p, r_q400p, r_q100y, r_q400y;

    assign n_year = tsd_pkg::YEAR_X_W'(i_year) + tsd_pkg::YEAR_SHIFT;
    assign n_prev = n_year - tsd_pkg::YEAR_X_W'(1);

    always_comb begin
        if (i_month < tsd_pkg::MONTH_JAN) begin
            n_month = tsd_pkg::MONTH_JAN;
        end else if (i_month > tsd_pkg::MONTH_DEC) begin
            n_month = tsd_pkg::MONTH_DEC;
        end else begin
            n_month = i_month;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.ld1) begin
            r_year   <= n_year;
            r_prev   <= n_prev;
            r_month  <= n_month;
            r_day    <= i_day;
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
            r_q100p  <= tsd_pkg::div25(n_prev[14:2]);
            r_q400p  <= tsd_pkg::div25(13'(n_prev[14:4]));
            r_q100y  <= tsd_pkg::div25(n_year[14:2]);
            r_q400y  <= tsd_pkg::div25(13'(n_year[14:4]));
        end
    end

    // stage 2: year days, partial day sum, leap flag, time of day
    logic [tsd_pkg::DAYS_W-1:0] r_p365;
    logic [tsd_pkg::PART_W-1:0] r_part;
    logic                       r_leap;
    logic [tsd_pkg::TOD_W-1:0]  r_tod2;
    logic                       n_leap;

    always_comb begin
        n_leap = ((r_year[1:0] == 2'd0) &&
                  (r_year != tsd_pkg::YEAR_X_W'(r_q100y) * tsd_pkg::YEAR_X_W'(100))) ||
                 (r_year == tsd_pkg::YEAR_X_W'(r_q400y) * tsd_pkg::YEAR_X_W'(400));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.ld2) begin
            r_p365 <= tsd_pkg::DAYS_W'(r_prev) * tsd_pkg::DAYS_W'(tsd_pkg::DAYS_PER_YEAR);
            r_part <= tsd_pkg::PART_W'(r_prev[14:2])
                    + tsd_pkg::PART_W'(r_q400p)
                    + tsd_pkg::PART_W'(tsd_pkg::CUM_DAYS[r_month - 4'd1])
                    + tsd_pkg::PART_W'(r_day)
                    - tsd_pkg::PART_W'(r_q100p);
            r_leap <= n_leap && (r_month > tsd_pkg::MONTH_FEB);
            r_tod2 <= tsd_pkg::TOD_W'(r_hour) * tsd_pkg::TOD_W'(tsd_pkg::SECS_PER_HOUR)
                    + tsd_pkg::TOD_W'(r_minute) * tsd_pkg::TOD_W'(tsd_pkg::SECS_PER_MIN)
                    + tsd_pkg::TOD_W'(r_second);
        end
    end

    // stage 3: total day count
    logic [tsd_pkg::DAYS_W-1:0] r_days;
    logic [tsd_pkg::TOD_W-1:0]  r_tod3;

    always_ff @(posedge i_clk) begin
        if (i_adv.ld3) begin
            r_days <= r_p365 + tsd_pkg::DAYS_W'(r_part) + tsd_pkg::DAYS_W'(r_leap);
            r_tod3 <= r_tod2;
        end
    end

    // stage 4: days to seconds
    logic [tsd_pkg::SECS_W-1:0] r_secs;

    always_ff @(posedge i_clk) begin
        if (i_adv.ld4) begin
            r_secs <= tsd_pkg::SECS_W'(r_days) * tsd_pkg::SECS_W'(tsd_pkg::SECS_PER_DAY)
                    + tsd_pkg::SECS_W'(r_tod3);
        end
    end

    assign o_secs = r_secs;

endmodule
